FILE: rtl/csdr_pkg.sv
// Shared widths, defaults and types for the cell set dedup and repair block.
package csdr_pkg;

    localparam int MAX_GRID_DEF = 1024;
    localparam int MAX_LIST_DEF = 64;

    localparam int VAL_W  = 16;
    localparam int GRID_W = 11;
    localparam int CELL_W = 11;
    localparam int DUP_W  = 7;
    localparam int DIV_W  = VAL_W + 1;

    localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(1024);

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] value;
    } t_mod_req;

endpackage

FILE: rtl/csdr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module csdr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = csdr_pkg::MAX_GRID_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/csdr_mod.sv
// Bit-serial remainder unit: wraps a signed value into 0..size-1.
module csdr_mod #(
    parameter int MAX_GRID = csdr_pkg::MAX_GRID_DEF,
    localparam int AW      = $clog2(MAX_GRID),
    localparam int SW      = $clog2(MAX_GRID + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  csdr_pkg::t_mod_req i_req,
    input  logic [SW-1:0]     i_size,
    output logic              o_done,
    output logic [AW-1:0]     o_rem
);

    import csdr_pkg::*;

    localparam int RW = SW + 1;
    localparam int NW = $clog2(DIV_W);

    logic             r_busy;
    logic             r_fix;
    logic             r_done;
    logic [NW-1:0]    r_cnt;
    logic [DIV_W-1:0] r_mag;
    logic             r_neg;
    logic [RW-1:0]    r_part;
    logic [AW-1:0]    r_rem;

    logic [RW-1:0]    size_ext;
    logic [RW-1:0]    trial;
    logic [RW-1:0]    step;
    logic [RW-1:0]    fix_val;
    logic [DIV_W-1:0] start_mag;

    assign size_ext  = {1'b0, i_size};
    assign trial     = {r_part[RW-2:0], r_mag[DIV_W-1]};
    assign step      = (trial >= size_ext) ? (trial - size_ext) : trial;
    // negative dividend: fold a nonzero remainder back into range
    assign fix_val   = (r_neg && (r_part != '0)) ? (size_ext - r_part) : r_part;
    assign start_mag = i_req.value[DIV_W-1] ? (~i_req.value + DIV_W'(1)) : i_req.value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == NW'(DIV_W - 1))) begin
                r_busy <= 1'b0;
                r_fix  <= 1'b1;
            end else if (r_fix) begin
                r_fix  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mag  <= start_mag;
            r_neg  <= i_req.value[DIV_W-1];
            r_part <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_mag  <= {r_mag[DIV_W-2:0], 1'b0};
            r_part <= step;
            r_cnt  <= r_cnt + NW'(1);
        end
        if (r_fix) begin
            r_rem <= AW'(fix_val);
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/cell_set_dedup_repair.sv
// Top level: occupancy map dedup, cyclic free-cell fill and ascending emit.
//
// Each input beat is wrapped into 1..S (S = grid_cells clamped to 2..MAX_GRID) by a
// bit-serial remainder unit and then marked in a one-bit occupancy RAM with a
// read-check-write pass. Beats past MAX_LIST items are dropped unless they end the
// list. The beat that ends the list also wraps the fill origin, then claims free
// cells at one RAM read per cycle, then scans the map from cell 1 at one cell per
// cycle up to the highest occupied cell, emitting each occupied cell and clearing
// it behind the scan; output stalls hold the scan. The input takes no beat while a
// list is being finished. After reset a clearing pass writes the whole map before
// the first beat is taken; grid_cells may be written meanwhile.
module cell_set_dedup_repair #(
    parameter int MAX_GRID = csdr_pkg::MAX_GRID_DEF,
    parameter int MAX_LIST = csdr_pkg::MAX_LIST_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [csdr_pkg::GRID_W-1:0] i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [csdr_pkg::VAL_W-1:0]  i_cell_value,
    input  logic [csdr_pkg::GRID_W-1:0] i_fill_origin,
    input  logic                        i_last_item,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [csdr_pkg::CELL_W-1:0] o_out_cell,
    output logic [csdr_pkg::DUP_W-1:0]  o_duplicate_total,
    output logic                        o_grid_overfull,
    output logic                        o_end_of_run
);

    import csdr_pkg::*;

    localparam int AW = $clog2(MAX_GRID);
    localparam int SW = $clog2(MAX_GRID + 1);
    localparam int PW = AW + 1;
    localparam int CW = $clog2(MAX_LIST + 1);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_MOD  = 3'd2;
    localparam logic [2:0] ST_MARK = 3'd3;
    localparam logic [2:0] ST_FILL = 3'd4;
    localparam logic [2:0] ST_SCAN = 3'd5;

    localparam logic PH_CELL = 1'b0;
    localparam logic PH_FILL = 1'b1;

    logic [GRID_W-1:0] r_grid_cells;
    logic [2:0]        r_state,    n_state;
    logic [PW-1:0]     r_ptr,      n_ptr;
    logic              r_chk_vld,  n_chk_vld;
    logic [AW-1:0]     r_chk_addr, n_chk_addr;
    logic [AW-1:0]     r_cand,     n_cand;
    logic [SW-1:0]     r_tries,    n_tries;
    logic [CW-1:0]     r_items,    n_items;
    logic [CW-1:0]     r_distinct, n_distinct;
    logic [CW-1:0]     r_dup,      n_dup;
    logic [CW-1:0]     r_emit,     n_emit;
    logic              r_last,     n_last;
    logic [GRID_W-1:0] r_fs,       n_fs;
    logic              r_phase,    n_phase;
    logic              r_overfull, n_overfull;
    logic              r_out_vld,  n_out_vld;
    logic [CELL_W-1:0] r_out_cell, n_out_cell;
    logic [DUP_W-1:0]  r_out_dup,  n_out_dup;
    logic              r_out_ovf,  n_out_ovf;
    logic              r_out_eor,  n_out_eor;

    logic [SW-1:0]     eff_size;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [0:0]        mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [0:0]        mem_rdata;
    t_mod_req          mod_req;
    logic              mod_done;
    logic [AW-1:0]     mod_rem;
    logic              out_free;
    logic              fill_go;
    logic              scan_hit;
    logic              scan_last;

    always_comb begin
        if (32'(r_grid_cells) > 32'(MAX_GRID)) begin
            eff_size = SW'(MAX_GRID);
        end else if (r_grid_cells < GRID_W'(2)) begin
            eff_size = SW'(2);
        end else begin
            eff_size = SW'(r_grid_cells);
        end
    end

    csdr_ram #(
        .WIDTH (1),
        .DEPTH (MAX_GRID)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    csdr_mod #(
        .MAX_GRID (MAX_GRID)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .i_size  (eff_size),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    assign out_free  = !r_out_vld || !i_out_stall;
    assign fill_go   = (r_tries < eff_size) && (r_distinct < r_items);
    assign scan_hit  = r_chk_vld && mem_rdata[0];
    assign scan_last = ((r_emit + CW'(1)) == r_distinct);

    always_comb begin
        n_state    = r_state;
        n_ptr      = r_ptr;
        n_chk_vld  = 1'b0;
        n_chk_addr = r_chk_addr;
        n_cand     = r_cand;
        n_tries    = r_tries;
        n_items    = r_items;
        n_distinct = r_distinct;
        n_dup      = r_dup;
        n_emit     = r_emit;
        n_last     = r_last;
        n_fs       = r_fs;
        n_phase    = r_phase;
        n_overfull = r_overfull;
        n_out_vld  = r_out_vld && i_out_stall;
        n_out_cell = r_out_cell;
        n_out_dup  = r_out_dup;
        n_out_ovf  = r_out_ovf;
        n_out_eor  = r_out_eor;
        mem_we     = 1'b0;
        mem_waddr  = r_chk_addr;
        mem_wdata  = 1'b0;
        mem_raddr  = r_chk_addr;
        mod_req.start = 1'b0;
        mod_req.value = {{(DIV_W - GRID_W){1'b0}}, r_fs} - DIV_W'(1);

        case (r_state)
            ST_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr[AW-1:0];
                n_ptr     = r_ptr + PW'(1);
                if (r_ptr == PW'(MAX_GRID - 1)) begin
                    n_ptr   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_last = i_last_item;
                    n_fs   = i_fill_origin;
                    if (r_items != CW'(MAX_LIST)) begin
                        mod_req.start = 1'b1;
                        mod_req.value = {i_cell_value[VAL_W-1], i_cell_value} - DIV_W'(1);
                        n_phase       = PH_CELL;
                        n_state       = ST_MOD;
                    end else if (i_last_item) begin
                        // list already full: skip marking, go straight to the fill
                        mod_req.start = 1'b1;
                        mod_req.value = {{(DIV_W - GRID_W){1'b0}}, i_fill_origin} - DIV_W'(1);
                        n_phase       = PH_FILL;
                        n_state       = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                if (mod_done) begin
                    if (r_phase == PH_CELL) begin
                        mem_raddr  = mod_rem;
                        n_chk_addr = mod_rem;
                        n_state    = ST_MARK;
                    end else begin
                        n_cand  = mod_rem;
                        n_tries = '0;
                        n_state = ST_FILL;
                    end
                end
            end
            ST_MARK: begin
                if (mem_rdata[0]) begin
                    n_dup = r_dup + CW'(1);
                end else begin
                    mem_we     = 1'b1;
                    mem_wdata  = 1'b1;
                    n_distinct = r_distinct + CW'(1);
                end
                n_items = r_items + CW'(1);
                if (r_last) begin
                    mod_req.start = 1'b1;
                    n_phase       = PH_FILL;
                    n_state       = ST_MOD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_FILL: begin
                // claim the cell read last cycle; each candidate is visited once
                if (r_chk_vld && !mem_rdata[0] && (r_distinct < r_items)) begin
                    mem_we     = 1'b1;
                    mem_wdata  = 1'b1;
                    n_distinct = r_distinct + CW'(1);
                end
                if (fill_go) begin
                    mem_raddr  = r_cand;
                    n_chk_vld  = 1'b1;
                    n_chk_addr = r_cand;
                    n_tries    = r_tries + SW'(1);
                    if (SW'(r_cand) == (eff_size - SW'(1))) begin
                        n_cand = '0;
                    end else begin
                        n_cand = r_cand + AW'(1);
                    end
                end else if (!r_chk_vld) begin
                    n_overfull = (r_distinct < r_items);
                    n_ptr      = '0;
                    n_emit     = '0;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_hit && !out_free) begin
                    // output still full: replay the same cell
                    mem_raddr  = r_chk_addr;
                    n_chk_vld  = 1'b1;
                    n_chk_addr = r_chk_addr;
                end else begin
                    if (scan_hit) begin
                        mem_we     = 1'b1;
                        mem_wdata  = 1'b0;
                        n_out_vld  = 1'b1;
                        n_out_cell = CELL_W'({1'b0, r_chk_addr} + PW'(1));
                        n_out_dup  = DUP_W'(r_dup);
                        n_out_ovf  = r_overfull;
                        n_out_eor  = scan_last;
                        n_emit     = r_emit + CW'(1);
                    end
                    if (scan_hit && scan_last) begin
                        n_items    = '0;
                        n_distinct = '0;
                        n_dup      = '0;
                        n_emit     = '0;
                        n_ptr      = '0;
                        n_state    = ST_IDLE;
                    end else if (r_ptr < PW'(MAX_GRID)) begin
                        mem_raddr  = r_ptr[AW-1:0];
                        n_chk_vld  = 1'b1;
                        n_chk_addr = r_ptr[AW-1:0];
                        n_ptr      = r_ptr + PW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cells <= GRID_RESET;
            r_state      <= ST_CLR;
            r_ptr        <= '0;
            r_chk_vld    <= 1'b0;
            r_items      <= '0;
            r_distinct   <= '0;
            r_dup        <= '0;
            r_emit       <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_grid_cells <= i_cfg_wdata;
            end
            r_state    <= n_state;
            r_ptr      <= n_ptr;
            r_chk_vld  <= n_chk_vld;
            r_items    <= n_items;
            r_distinct <= n_distinct;
            r_dup      <= n_dup;
            r_emit     <= n_emit;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_addr <= n_chk_addr;
        r_cand     <= n_cand;
        r_tries    <= n_tries;
        r_last     <= n_last;
        r_fs       <= n_fs;
        r_phase    <= n_phase;
        r_overfull <= n_overfull;
        r_out_cell <= n_out_cell;
        r_out_dup  <= n_out_dup;
        r_out_ovf  <= n_out_ovf;
        r_out_eor  <= n_out_eor;
    end

    assign o_in_stall        = (r_state != ST_IDLE);
    assign o_out_valid       = r_out_vld;
    assign o_out_cell        = r_out_cell;
    assign o_duplicate_total = r_out_dup;
    assign o_grid_overfull   = r_out_ovf;
    assign o_end_of_run      = r_out_eor;

`ifndef SYNTH
    a_distinct_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_CLR) |-> (r_distinct <= r_items))
        else $error("distinct count exceeds item count");

    a_fill_sets_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL && mem_we) |-> mem_wdata[0])
        else $error("fill pass cleared a map cell");

    a_run_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && n_state == ST_IDLE)
            |=> (o_out_valid && o_end_of_run && r_items == '0 && r_distinct == '0))
        else $error("run ended without final beat or counter clear");

    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_emit < r_distinct))
        else $error("scan emitted more cells than are occupied");
`endif

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for cell_set_dedup_repair: wrap, dedup, free-cell fill and ordered emit.
module tb;
    import csdr_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE_CYCLES = 48;

    typedef struct {
        logic [CELL_W-1:0] cell_no;
        logic [DUP_W-1:0]  dups;
        logic              overfull;
        logic              run_end;
    } t_cell_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [GRID_W-1:0]   i_cfg_wdata = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [VAL_W-1:0]    i_cell_value = '0;
    logic [GRID_W-1:0]   i_fill_origin = '0;
    logic                i_last_item = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [CELL_W-1:0]   o_out_cell;
    logic [DUP_W-1:0]    o_duplicate_total;
    logic                o_grid_overfull;
    logic                o_end_of_run;

    // predictor state
    bit                  occupied [MAX_GRID_DEF];
    int                  items_taken;
    int                  distinct_cells;
    int                  repeat_cells;
    logic [GRID_W-1:0]   grid_reg = GRID_RESET;
    t_cell_result        pending_cells [$];

    int gap_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int beats_sent = 0;
    int lists_sent = 0;
    int results_checked = 0;
    int grid_writes = 0;
    int cycle_count = 0;

    cell_set_dedup_repair dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_cell_value      (i_cell_value),
        .i_fill_origin     (i_fill_origin),
        .i_last_item       (i_last_item),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_out_cell        (o_out_cell),
        .o_duplicate_total (o_duplicate_total),
        .o_grid_overfull   (o_grid_overfull),
        .o_end_of_run      (o_end_of_run)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int grid_size();
        int s;
        s = int'(grid_reg);
        if (s < 2) s = 2;
        if (s > MAX_GRID_DEF) s = MAX_GRID_DEF;
        return s;
    endfunction

    // map any integer into 1..s
    function automatic int wrap_into_grid(int v, int s);
        int r;
        r = (v - 1) % s;
        if (r < 0) r += s;
        return r + 1;
    endfunction

    function automatic void predict_beat(logic signed [VAL_W-1:0] value,
                                         logic [GRID_W-1:0] fill, logic last);
        int s;
        int c;
        int cand;
        int tries;
        int n;
        int m;
        logic full;
        t_cell_result r;
        s = grid_size();
        if (items_taken < MAX_LIST_DEF) begin
            c = wrap_into_grid(int'(value), s);
            items_taken++;
            if (occupied[c-1]) begin
                repeat_cells++;
            end else begin
                occupied[c-1] = 1'b1;
                distinct_cells++;
            end
        end
        if (!last) return;
        cand = wrap_into_grid(int'(fill), s);
        tries = 0;
        while (distinct_cells < items_taken && tries < s) begin
            if (!occupied[cand-1]) begin
                occupied[cand-1] = 1'b1;
                distinct_cells++;
            end
            cand = (cand == s) ? 1 : cand + 1;
            tries++;
        end
        full = (distinct_cells < items_taken);
        m = 0;
        for (int i = 0; i < MAX_GRID_DEF && m < MAX_LIST_DEF; i++) begin
            if (occupied[i]) m++;
        end
        n = 0;
        for (int i = 0; i < MAX_GRID_DEF && n < MAX_LIST_DEF; i++) begin
            if (occupied[i]) begin
                r.cell_no = CELL_W'(i + 1);
                r.dups = DUP_W'(repeat_cells);
                r.overfull = full;
                r.run_end = (n == m - 1);
                pending_cells.insert(pending_cells.size(), r);
                n++;
            end
        end
        foreach (occupied[i]) occupied[i] = 1'b0;
        items_taken = 0;
        distinct_cells = 0;
        repeat_cells = 0;
    endfunction

    task automatic send_cell(input logic signed [VAL_W-1:0] value,
                             input logic [GRID_W-1:0] fill, input logic last);
        while ($urandom_range(99) < gap_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_cell_value <= value;
        i_fill_origin <= fill;
        i_last_item <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_beat(value, fill, last);
        beats_sent++;
        if (last) lists_sent++;
    endtask

    // drop valid, drain all expected results, then let a dropped or plain beat finish
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_grid(input logic [GRID_W-1:0] cells);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= cells;
        grid_reg = cells;
        grid_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [GRID_W-1:0] pick_grid();
        case ($urandom_range(9))
            0: return '0;
            1: return GRID_W'(1);
            2: return GRID_W'(2);
            3: return '1;
            4: return GRID_W'(MAX_GRID_DEF);
            5: return GRID_W'($urandom_range(3, 2046));
            default: return GRID_W'($urandom_range(3, 40));
        endcase
    endfunction

    // values at and around both ends of the 16-bit range, zero and wrap points
    task automatic test_wrap_extremes();
        send_cell(16'sh8000, 11'd5, 1'b0);
        send_cell(16'sh7fff, 11'd5, 1'b0);
        send_cell(16'sd0, 11'd5, 1'b0);
        send_cell(16'sd1, 11'd5, 1'b0);
        send_cell(16'sd1024, 11'd5, 1'b0);
        send_cell(16'sd1025, 11'd5, 1'b0);
        send_cell(-16'sd1, 11'd5, 1'b0);
        send_cell(16'sd1, 11'd5, 1'b0);
        // fill origin zero wraps to the top cell, then the fill wraps to 1
        send_cell(16'sd512, 11'd0, 1'b1);
        settle();
    endtask

    task automatic test_fill_origin_ends();
        write_grid(GRID_W'(MAX_GRID_DEF));
        send_cell(-16'sd5, 11'd1, 1'b1);
        send_cell(16'sd700, 11'd1024, 1'b0);
        send_cell(16'sd700, 11'd1024, 1'b1);
        settle();
    endtask

    // sizes below the minimum clamp to 2; three items cannot fit
    task automatic test_small_grid_overfull();
        write_grid('0);
        send_cell(16'sd5, 11'd2047, 1'b0);
        send_cell(16'sd6, 11'd2047, 1'b0);
        send_cell(16'sd7, 11'd2047, 1'b1);
        settle();
        write_grid(GRID_W'(1));
        send_cell(-16'sd3, 11'd0, 1'b1);
        settle();
        write_grid('1);
    endtask

    // cells marked under a large grid stay marked after it shrinks
    task automatic test_resize_mid_list();
        send_cell(16'sd1000, 11'd0, 1'b0);
        send_cell(16'sd999, 11'd0, 1'b0);
        settle();
        write_grid(GRID_W'(16));
        send_cell(16'sd3, 11'd0, 1'b0);
        send_cell(16'sd3, 11'd16, 1'b1);
        settle();
    endtask

    task automatic test_random_phase(input int count, input int gap, input int stall);
        int sent;
        int len;
        int mode;
        int s;
        logic signed [VAL_W-1:0] v;
        gap_pct = gap;
        stall_pct = stall;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(3) == 0) begin
                settle();
                write_grid(pick_grid());
            end
            s = grid_size();
            // some lists run past the item limit
            len = ($urandom_range(19) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 12);
            mode = $urandom_range(9);
            for (int k = 0; k < len; k++) begin
                if (mode < 6) begin
                    v = VAL_W'(int'($urandom_range(0, 2 * s)) - s / 2);
                end else if (mode < 8) begin
                    v = VAL_W'($urandom());
                end else begin
                    case ($urandom_range(4))
                        0: v = 16'sh8000;
                        1: v = 16'sh7fff;
                        2: v = 16'sd0;
                        3: v = -16'sd1;
                        default: v = VAL_W'($urandom());
                    endcase
                end
                send_cell(v, GRID_W'($urandom_range(0, 2047)), k == len - 1);
            end
            sent += len;
        end
        settle();
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin : check_results
        t_cell_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_cells.size() == 0) begin
                $error("unexpected result beat: out_cell %0d", o_out_cell);
                mismatches++;
            end else begin
                want = pending_cells.pop_front();
                results_checked++;
                if (o_out_cell !== want.cell_no) begin
                    $error("out_cell expected %0d got %0d", want.cell_no, o_out_cell);
                    mismatches++;
                end
                if (o_duplicate_total !== want.dups) begin
                    $error("duplicate_total expected %0d got %0d", want.dups,
                           o_duplicate_total);
                    mismatches++;
                end
                if (o_grid_overfull !== want.overfull) begin
                    $error("grid_overfull expected %0d got %0d", want.overfull,
                           o_grid_overfull);
                    mismatches++;
                end
                if (o_end_of_run !== want.run_end) begin
                    $error("end_of_run expected %0d got %0d", want.run_end, o_end_of_run);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_wrap_extremes();
        test_fill_origin_ends();
        test_small_grid_overfull();
        test_resize_mid_list();
        test_random_phase(100, 0, 0);
        test_random_phase(100, 58, 0);
        test_random_phase(100, 0, 58);
        test_random_phase(100, 29, 29);
        settle();
        $display("%0d cell beats in %0d lists, %0d grid size writes", beats_sent, lists_sent,
                 grid_writes);
        $display("%0d result beats checked under sender gaps and receiver stalls",
                 results_checked);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/csdr_pkg.sv
rtl/csdr_ram.sv
rtl/csdr_mod.sv
rtl/cell_set_dedup_repair.sv
sim/tb.sv
